// File: hdl/mbht_pkg.sv
package mbht_pkg;

  localparam int NUM_BUCKETS  = 16;
  localparam int BUCKET_SLOTS = 8;

  localparam int ITEM_W   = 31;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 5;
  localparam int BUCKET_W = $clog2(NUM_BUCKETS);
  localparam int SLOT_W   = $clog2(BUCKET_SLOTS);
  localparam int FILL_W   = $clog2(BUCKET_SLOTS + 1);
  localparam int ADDR_W   = BUCKET_W + SLOT_W;
  localparam int DEPTH    = NUM_BUCKETS * BUCKET_SLOTS;

  // The remainder is built four item bits per step over a zero-padded item.
  localparam int MOD_DIGIT_W = 4;
  localparam int MOD_STEPS   = (ITEM_W + MOD_DIGIT_W - 1) / MOD_DIGIT_W;
  localparam int MOD_W       = MOD_STEPS * MOD_DIGIT_W;
  localparam int MOD_CNT_W   = $clog2(MOD_STEPS);

  localparam logic [CNT_W-1:0] BUCKET_COUNT_RESET = CNT_W'(10);

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_LOOKUP,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;

endpackage

// File: hdl/mbht_if.sv
interface mbht_req_if import mbht_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [ITEM_W-1:0] item_value;

  modport source (output valid, output req_type, output item_value, input ready);
  modport sink (input valid, input req_type, input item_value, output ready);
endinterface

interface mbht_res_if import mbht_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BUCKET_W-1:0] bucket_index;
  logic [SLOT_W-1:0]   slot_index;
  logic [FILL_W-1:0]   bucket_fill;

  modport source (
    output valid, output status, output bucket_index, output slot_index,
    output bucket_fill, input ready
  );
  modport sink (
    input valid, input status, input bucket_index, input slot_index,
    input bucket_fill, output ready
  );
endinterface

// File: hdl/mbht_ram.sv
module mbht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/mbht_mod_step.sv
module mbht_mod_step import mbht_pkg::*; (
  input  logic [CNT_W-1:0]       rem_in,
  input  logic [MOD_DIGIT_W-1:0] digit,
  input  logic [CNT_W-1:0]       divisor,
  output logic [CNT_W-1:0]       rem_out
);

  // Restoring remainder, one bit per inner step. The remainder stays below
  // the divisor, so shifting in a bit never overflows the register.
  always_comb begin
    logic [CNT_W-1:0] r;
    r = rem_in;
    for (int k = 0; k < MOD_DIGIT_W; k++) begin
      r = {r[CNT_W-2:0], digit[MOD_DIGIT_W-1-k]};
      if (r >= divisor) begin
        r = r - divisor;
      end
    end
    rem_out = r;
  end

endmodule

// File: hdl/modulo_bucket_hash_table.sv
// Insert, and remove from an empty bucket, pass through 8 remainder steps, one table lookup and
// one result load after acceptance; clear and unused requests go straight to the result load.
// Remove from a non-empty bucket scans the items in it, then moves the later items down.
// Throughput: one transaction at a time; a request is taken the cycle after the previous
// result is loaded; a result still held stalls that load.
// Reset (synchronous): all buckets empty, bucket count 10, no result pending.
module modulo_bucket_hash_table import mbht_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  mbht_req_if.sink         req,
  mbht_res_if.source       res
);

  state_t state, state_next;

  logic [CNT_W-1:0]     bucket_count;
  logic [CNT_W-1:0]     modulus;
  logic [REQ_W-1:0]     req_code;
  logic [ITEM_W-1:0]    item;
  logic [MOD_W-1:0]     digits;
  logic [MOD_CNT_W-1:0] mod_cnt;
  logic [CNT_W-1:0]     rem;
  logic [CNT_W-1:0]     rem_next;
  logic [BUCKET_W-1:0]  bucket;
  logic [SLOT_W-1:0]    idx;
  logic [FILL_W-1:0]    cur_fill;
  logic [FILL_W-1:0]    fills [NUM_BUCKETS];
  logic [FILL_W-1:0]    fill_rd;
  logic [FILL_W-1:0]    idx_ext;

  logic [STATUS_W-1:0]  res_status;
  logic [BUCKET_W-1:0]  res_bucket;
  logic [SLOT_W-1:0]    res_slot;
  logic [FILL_W-1:0]    res_fill;
  logic                 out_valid;
  logic                 out_load;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [ITEM_W-1:0]    ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [ITEM_W-1:0]    ram_rdata;

  logic last_mod;
  logic bucket_full;
  logic scan_hit;
  logic scan_more;
  logic shift_more;

  // A count of zero hashes as one bucket, a count above the table size as all buckets.
  always_comb begin
    if (bucket_count == '0) begin
      modulus = CNT_W'(1);
    end else if (bucket_count > CNT_W'(NUM_BUCKETS)) begin
      modulus = CNT_W'(NUM_BUCKETS);
    end else begin
      modulus = bucket_count;
    end
  end

  mbht_mod_step u_mod_step (
    .rem_in  (rem),
    .digit   (digits[MOD_W-1 -: MOD_DIGIT_W]),
    .divisor (modulus),
    .rem_out (rem_next)
  );

  mbht_ram #(
    .WIDTH (ITEM_W),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign bucket      = rem[BUCKET_W-1:0];
  assign fill_rd     = fills[bucket];
  assign idx_ext     = {{(FILL_W-SLOT_W){1'b0}}, idx};
  assign last_mod    = (mod_cnt == MOD_CNT_W'(MOD_STEPS - 1));
  assign bucket_full = (fill_rd >= FILL_W'(BUCKET_SLOTS));
  assign scan_hit    = (ram_rdata == item);
  assign scan_more   = ((idx_ext + FILL_W'(1)) < cur_fill);
  assign shift_more  = ((idx_ext + FILL_W'(2)) < cur_fill);
  assign out_load    = (state == S_DONE) && (!out_valid || res.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.req_type == REQ_INSERT || req.req_type == REQ_REMOVE) begin
            state_next = S_MOD;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_MOD: begin
        if (last_mod) begin
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (req_code == REQ_INSERT || fill_rd == '0) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: state_next = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (scan_hit) begin
          state_next = scan_more ? S_SHIFT_RD : S_DONE;
        end else begin
          state_next = scan_more ? S_SCAN_RD : S_DONE;
        end
      end
      S_SHIFT_RD: state_next = S_SHIFT_WR;
      S_SHIFT_WR: state_next = shift_more ? S_SHIFT_RD : S_DONE;
      S_DONE: begin
        if (!out_valid || res.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = {bucket, idx};
    ram_wdata = item;
    ram_raddr = {bucket, idx};
    unique case (state)
      S_IDLE: req.ready = 1'b1;
      S_LOOKUP: begin
        ram_we    = (req_code == REQ_INSERT) && !bucket_full;
        ram_waddr = {bucket, fill_rd[SLOT_W-1:0]};
      end
      S_SHIFT_RD: ram_raddr = {bucket, idx + SLOT_W'(1)};
      S_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      bucket_count <= BUCKET_COUNT_RESET;
      out_valid    <= 1'b0;
      for (int b = 0; b < NUM_BUCKETS; b++) begin
        fills[b] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_we) begin
        bucket_count <= cfg_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            req_code   <= req.req_type;
            item       <= req.item_value;
            digits     <= MOD_W'(req.item_value);
            mod_cnt    <= '0;
            rem        <= '0;
            res_status <= ST_DONE;
            res_bucket <= '0;
            res_slot   <= '0;
            res_fill   <= '0;
            if (req.req_type == REQ_CLEAR) begin
              for (int b = 0; b < NUM_BUCKETS; b++) begin
                fills[b] <= '0;
              end
            end
          end
        end
        S_MOD: begin
          rem     <= rem_next;
          digits  <= digits << MOD_DIGIT_W;
          mod_cnt <= mod_cnt + 1'b1;
        end
        S_LOOKUP: begin
          res_bucket <= bucket;
          cur_fill   <= fill_rd;
          idx        <= '0;
          if (req_code == REQ_INSERT) begin
            if (bucket_full) begin
              res_status <= ST_FULL;
              res_fill   <= fill_rd;
            end else begin
              res_slot      <= fill_rd[SLOT_W-1:0];
              res_fill      <= fill_rd + FILL_W'(1);
              fills[bucket] <= fill_rd + FILL_W'(1);
            end
          end else begin
            res_fill <= fill_rd;
            if (fill_rd == '0) begin
              res_status <= ST_NOT_FOUND;
            end
          end
        end
        S_SCAN_CMP: begin
          if (scan_hit) begin
            res_slot <= idx;
            // A hit on the last item needs no move; the bucket just shrinks.
            if (!scan_more) begin
              fills[bucket] <= cur_fill - FILL_W'(1);
              res_fill      <= cur_fill - FILL_W'(1);
            end
          end else if (scan_more) begin
            idx <= idx + SLOT_W'(1);
          end else begin
            res_status <= ST_NOT_FOUND;
          end
        end
        S_SHIFT_WR: begin
          idx <= idx + SLOT_W'(1);
          if (!shift_more) begin
            fills[bucket] <= cur_fill - FILL_W'(1);
            res_fill      <= cur_fill - FILL_W'(1);
          end
        end
        default: begin
        end
      endcase

      if (out_load) begin
        res.status       <= res_status;
        res.bucket_index <= res_bucket;
        res.slot_index   <= res_slot;
        res.bucket_fill  <= res_fill;
      end
    end
  end

  assign res.valid = out_valid;

endmodule

// File: tb/hash_table_monitor.sv
module hash_table_monitor import mbht_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  mbht_req_if              req,
  mbht_res_if              res,
  output int               fail_count,
  output int               pending,
  output int               results_seen
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BUCKET_W-1:0] bucket_index;
    logic [SLOT_W-1:0]   slot_index;
    logic [FILL_W-1:0]   bucket_fill;
  } lookup_result_t;

  logic [ITEM_W-1:0] chain_items [NUM_BUCKETS][BUCKET_SLOTS];
  int unsigned       chain_len [NUM_BUCKETS];
  logic [CNT_W-1:0]  modulus_reg;
  lookup_result_t    awaited_results [$];
  int                mismatch_total = 0;
  int                result_total = 0;

  // A zero count hashes everything to bucket 0; counts past the table size saturate.
  function automatic int unsigned live_buckets();
    if (modulus_reg == 0) return 1;
    if (modulus_reg > NUM_BUCKETS) return NUM_BUCKETS;
    return modulus_reg;
  endfunction

  function automatic lookup_result_t serve_request(input logic [REQ_W-1:0] kind,
                                                   input logic [ITEM_W-1:0] value);
    lookup_result_t outcome;
    int unsigned    bucket;
    int unsigned    count;
    int unsigned    pos;
    int unsigned    j;
    outcome = '0;
    outcome.status = ST_DONE;
    if (kind == REQ_CLEAR) begin
      foreach (chain_len[i]) chain_len[i] = 0;
    end else if (kind == REQ_INSERT || kind == REQ_REMOVE) begin
      bucket = value % live_buckets();
      count = chain_len[bucket];
      outcome.bucket_index = BUCKET_W'(bucket);
      if (kind == REQ_INSERT) begin
        if (count >= BUCKET_SLOTS) begin
          outcome.status = ST_FULL;
        end else begin
          chain_items[bucket][count] = value;
          outcome.slot_index = SLOT_W'(count);
          count++;
          chain_len[bucket] = count;
        end
      end else begin
        pos = 0;
        while (pos < count && chain_items[bucket][pos] != value) pos++;
        if (pos >= count) begin
          outcome.status = ST_NOT_FOUND;
        end else begin
          outcome.slot_index = SLOT_W'(pos);
          // Later items move down one slot so the chain keeps its order.
          for (j = pos; j + 1 < count; j++) chain_items[bucket][j] = chain_items[bucket][j + 1];
          count--;
          chain_len[bucket] = count;
        end
      end
      outcome.bucket_fill = FILL_W'(count);
    end
    return outcome;
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      mismatch_total++;
    end
  endfunction

  always @(posedge clk) begin
    lookup_result_t want;
    if (rst) begin
      modulus_reg = BUCKET_COUNT_RESET;
      foreach (chain_len[i]) chain_len[i] = 0;
      awaited_results.delete();
    end else begin
      // The result is handled first: the next request may be taken at the same edge.
      if (res.valid && res.ready) begin
        result_total++;
        if (awaited_results.size() == 0) begin
          $error("unexpected result transaction: status %0d bucket %0d slot %0d fill %0d",
                 res.status, res.bucket_index, res.slot_index, res.bucket_fill);
          mismatch_total++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", 32'(want.status), 32'(res.status));
          check_field("bucket_index", 32'(want.bucket_index), 32'(res.bucket_index));
          check_field("slot_index", 32'(want.slot_index), 32'(res.slot_index));
          check_field("bucket_fill", 32'(want.bucket_fill), 32'(res.bucket_fill));
        end
      end
      if (req.valid && req.ready) begin
        awaited_results.push_back(serve_request(req.req_type, req.item_value));
      end
      if (cfg_we) modulus_reg = cfg_wdata;
    end
    fail_count   <= mismatch_total;
    pending      <= awaited_results.size();
    results_seen <= result_total;
  end

endmodule

// File: tb/tb_modulo_bucket_hash_table.sv
module tb_modulo_bucket_hash_table;
  import mbht_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int HOLD_CYCLES      = 240;
  localparam int STALL_LIMIT      = 2500;
  localparam int DRAIN_CYCLES     = 60;
  localparam int RANDOM_PER_PHASE = 178;
  localparam int PHASES           = 8;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  mbht_req_if req_ch ();
  mbht_res_if res_ch ();

  int fail_count;
  int pending;
  int results_seen;
  int requests_sent  = 0;
  int settings_used  = 0;
  int idle_cycles    = 0;
  bit quiet_tail     = 1'b0;
  bit finished       = 1'b0;
  logic [ITEM_W-1:0] stored_items [$];
  logic [CNT_W-1:0]  phase_setting [PHASES];

  modulo_bucket_hash_table dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .res       (res_ch)
  );

  hash_table_monitor monitor (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .req          (req_ch),
    .res          (res_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || finished || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stalls, two long hold-offs that back the block up, and none at the end.
  initial begin
    int hold_mark;
    hold_mark = 300;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (results_seen >= hold_mark && hold_mark <= 800) begin
        hold_mark += 500;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (quiet_tail) begin
        res_ch.ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [ITEM_W-1:0] value);
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.item_value <= value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    requests_sent++;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // Returns once every accepted request has produced its result transaction.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_seen != requests_sent) @(posedge clk);
  endtask

  task automatic write_bucket_count(input logic [CNT_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [ITEM_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0:       return ITEM_W'($urandom_range(0, 63));
      1:       return {ITEM_W{1'b1}} - ITEM_W'($urandom_range(0, 63));
      default: return ITEM_W'($urandom);
    endcase
  endfunction

  function automatic void remember_item(input logic [ITEM_W-1:0] value);
    stored_items.push_back(value);
    if (stored_items.size() > 64) void'(stored_items.pop_front());
  endfunction

  // Mostly inserts and removes of items known to be stored, so chains fill and shift.
  task automatic send_random_request();
    int roll;
    int pick;
    logic [ITEM_W-1:0] value;
    roll = $urandom_range(0, 99);
    value = pick_value();
    if (roll < 45) begin
      remember_item(value);
      send_request(REQ_INSERT, value);
    end else if (roll < 75 && stored_items.size() > 0) begin
      pick = $urandom_range(0, stored_items.size() - 1);
      value = stored_items[pick];
      stored_items.delete(pick);
      send_request(REQ_REMOVE, value);
    end else if (roll < 88) begin
      send_request(REQ_REMOVE, value);
    end else if (roll < 94 && stored_items.size() > 0) begin
      value = stored_items[$urandom_range(0, stored_items.size() - 1)];
      remember_item(value);
      send_request(REQ_INSERT, value);
    end else if (roll < 97) begin
      stored_items.delete();
      send_request(REQ_CLEAR, value);
    end else begin
      send_request(REQ_UNUSED, value);
    end
  endtask

  initial begin
    logic [ITEM_W-1:0] chain_fill [8];
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= REQ_INSERT;
    req_ch.item_value <= '0;
    chain_fill = '{2, 6, 2, 10, 14, 18, 22, 26};
    phase_setting[0] = 5'd0;
    phase_setting[1] = 5'd1;
    phase_setting[2] = 5'd16;
    phase_setting[3] = 5'd31;
    phase_setting[4] = CNT_W'($urandom_range(2, 15));
    phase_setting[5] = CNT_W'($urandom_range(17, 30));
    phase_setting[6] = 5'd10;
    phase_setting[7] = CNT_W'($urandom_range(1, 16));
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_bucket_count(5'd4);
    send_request(REQ_INSERT, '0);
    send_request(REQ_INSERT, {ITEM_W{1'b1}});
    send_request(REQ_REMOVE, {ITEM_W{1'b1}});
    // Remove from an empty bucket.
    send_request(REQ_REMOVE, 31'd5);
    // Fill bucket 2 with a duplicate inside, then overflow it.
    foreach (chain_fill[k]) send_request(REQ_INSERT, chain_fill[k]);
    send_request(REQ_INSERT, 31'd30);
    send_request(REQ_REMOVE, 31'd2);
    send_request(REQ_REMOVE, 31'd14);
    // Missing item in a bucket that is not empty.
    send_request(REQ_REMOVE, 31'd34);
    send_request(REQ_REMOVE, 31'd26);
    send_request(REQ_UNUSED, {ITEM_W{1'b1}});
    send_request(REQ_CLEAR, {ITEM_W{1'b1}});
    send_request(REQ_REMOVE, 31'd6);
    send_request(REQ_INSERT, '0);

    for (int p = 0; p < PHASES; p++) begin
      write_bucket_count(phase_setting[p]);
      if (p == PHASES - 1) quiet_tail = 1'b1;
      repeat (RANDOM_PER_PHASE) send_random_request();
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    finished = 1'b1;
    $display("Checked %0d results from %0d requests over %0d bucket-count settings.",
             results_seen, requests_sent, settings_used);
    $display("Traffic mixed directed chain cases with random requests and %0d-cycle hold-offs.",
             HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/mbht_pkg.sv
hdl/mbht_if.sv
hdl/mbht_ram.sv
hdl/mbht_mod_step.sv
hdl/modulo_bucket_hash_table.sv
tb/hash_table_monitor.sv
tb/tb_modulo_bucket_hash_table.sv
